### design/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by checker modules
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high
`define ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst is high
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/fqs_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_pkg
// Field widths and action/status codes of the FIFO queue with search.
// ---------------------------------------------------------------------------
package fqs_pkg;

  localparam int ACTION_W  = 2;
  localparam int OPERAND_W = 32;
  localparam int STATUS_W  = 3;
  localparam int VALUE_W   = 32;
  localparam int POS_W     = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT  = 2'd0,
    ACT_DELETE  = 2'd1,
    ACT_DISPLAY = 2'd2,
    ACT_SEARCH  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DELETED   = 3'd1,
    ST_ELEMENT   = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

endpackage

### design/fqs_req_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_req_if
// Request channel: action and operand with valid/ready.
// ---------------------------------------------------------------------------
interface fqs_req_if;
  logic                                 valid;
  logic                                 ready;
  fqs_pkg::action_t                     action;
  logic signed [fqs_pkg::OPERAND_W-1:0] operand;

  modport source (output valid, action, operand, input ready);
  modport sink   (input valid, action, operand, output ready);
endinterface

### design/fqs_rsp_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_rsp_if
// Response channel: status, value, position and last with valid/ready.
// ---------------------------------------------------------------------------
interface fqs_rsp_if;
  logic                               valid;
  logic                               ready;
  fqs_pkg::status_t                   status;
  logic signed [fqs_pkg::VALUE_W-1:0] value_out;
  logic [fqs_pkg::POS_W-1:0]          position;
  logic                               last;

  modport source (output valid, status, value_out, position, last, input ready);
  modport sink   (input valid, status, value_out, position, last, output ready);
endinterface

### design/fqs_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/fifo_queue_with_search_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fifo_queue_with_search_unit
// Ring-buffer FIFO of words with insert, delete, display and linear search.
// ---------------------------------------------------------------------------
// Insert and any action on an empty queue: result registered in S_START.
// Delete: result registered in S_PROC, after S_START issues the RAM read.
// Display: first result in S_PROC, then one per cycle unless the response stalls.
// Search: last result from S_FLUSH; the single RAM read port visits one entry per cycle
// unless a match waits on a stalled response, and the comparator checks it the cycle after.
// Request ready is high only between transactions; stalls on response add cycles.
// Synchronous reset clears head, count and output valid; RAM contents are kept.
module fifo_queue_with_search_unit #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  fqs_req_if.sink    request,
  fqs_rsp_if.source  response
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int VW = fqs_pkg::VALUE_W;
  localparam int PW = fqs_pkg::POS_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PROC,
    S_FLUSH
  } state_t;

  state_t                  state;
  fqs_pkg::action_t        act;
  logic [DATA_WIDTH-1:0]   key;
  logic [AW-1:0]           head;
  logic [CW-1:0]           count;
  logic [AW-1:0]           rptr;
  logic [CW-1:0]           idx;
  logic                    pend_valid;
  logic [VW-1:0]           pend_value;
  logic [PW-1:0]           pend_pos;

  logic                    out_valid;
  fqs_pkg::status_t        out_status;
  logic [VW-1:0]           out_value;
  logic [PW-1:0]           out_pos;
  logic                    out_last;

  logic                    out_free;
  logic                    out_load;
  logic                    full;
  logic                    match;
  logic                    adv;
  logic                    scan_end;
  logic [CW-1:0]           pos_full;
  logic [PW-1:0]           pos_trunc;
  logic [AW:0]             tail_sum;
  logic [AW-1:0]           tail;
  logic                    wr_en;
  logic [AW-1:0]           rd_addr;
  logic [DATA_WIDTH-1:0]   rd_data;
  logic [VW-1:0]           rd_val;

  function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
    if (p == AW'(DEPTH - 1)) begin
      return '0;
    end
    return p + AW'(1);
  endfunction

  assign out_free  = !out_valid || response.ready;
  assign full      = (count == CW'(DEPTH));
  assign match     = (rd_data == key);
  assign pos_full  = idx + CW'(1);
  assign pos_trunc = PW'(pos_full);
  assign scan_end  = (pos_full == count);
  assign rd_val    = VW'(rd_data);

  // Tail slot: head plus count, wrapped once around the ring
  assign tail_sum = {1'b0, head} + (AW + 1)'(count);
  assign tail     = (tail_sum >= (AW + 1)'(DEPTH)) ?
                    AW'(tail_sum - (AW + 1)'(DEPTH)) : AW'(tail_sum);

  assign wr_en = (state == S_START) && (act == fqs_pkg::ACT_INSERT) && out_free && !full;

  always_comb begin
    adv = 1'b0;
    if (state == S_PROC) begin
      unique case (act)
        fqs_pkg::ACT_DISPLAY: adv = out_free;
        fqs_pkg::ACT_SEARCH:  adv = !match || !pend_valid || out_free;
        fqs_pkg::ACT_INSERT,
        fqs_pkg::ACT_DELETE:  adv = 1'b0;
      endcase
    end
  end

  // A new result enters the output register this cycle
  assign out_load =
    ((state == S_START) && out_free &&
     ((act == fqs_pkg::ACT_INSERT) || (count == '0))) ||
    ((state == S_PROC) && (act == fqs_pkg::ACT_DELETE) && out_free) ||
    ((state == S_PROC) && (act == fqs_pkg::ACT_DISPLAY) && adv) ||
    ((state == S_PROC) && (act == fqs_pkg::ACT_SEARCH) && adv && match && pend_valid) ||
    ((state == S_FLUSH) && out_free);

  // Prefetch the next entry as soon as the current one is consumed
  assign rd_addr = adv ? ring_inc(rptr) : rptr;

  fqs_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail),
    .wr_data (key),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      count      <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_valid && response.ready && !out_load) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        rptr <= ring_inc(rptr);
        idx  <= pos_full;
      end
      unique case (state)
        S_IDLE: begin
          if (request.valid) begin
            act        <= request.action;
            key        <= DATA_WIDTH'($unsigned(request.operand));
            rptr       <= head;
            idx        <= '0;
            pend_valid <= 1'b0;
            state      <= S_START;
          end
        end
        S_START: begin
          if (act == fqs_pkg::ACT_INSERT) begin
            if (out_free) begin
              out_valid <= 1'b1;
              out_value <= '0;
              out_pos   <= '0;
              out_last  <= 1'b1;
              if (full) begin
                out_status <= fqs_pkg::ST_FULL;
              end else begin
                out_status <= fqs_pkg::ST_INSERTED;
                count      <= count + CW'(1);
              end
              state <= S_IDLE;
            end
          end else if (count == '0) begin
            if (out_free) begin
              out_valid  <= 1'b1;
              out_status <= fqs_pkg::ST_EMPTY;
              out_value  <= '0;
              out_pos    <= '0;
              out_last   <= 1'b1;
              state      <= S_IDLE;
            end
          end else begin
            state <= S_PROC;
          end
        end
        S_PROC: begin
          unique case (act)
            fqs_pkg::ACT_DELETE: begin
              if (out_free) begin
                out_valid  <= 1'b1;
                out_status <= fqs_pkg::ST_DELETED;
                out_value  <= rd_val;
                out_pos    <= '0;
                out_last   <= 1'b1;
                head       <= ring_inc(head);
                count      <= count - CW'(1);
                state      <= S_IDLE;
              end
            end
            fqs_pkg::ACT_DISPLAY: begin
              if (adv) begin
                out_valid  <= 1'b1;
                out_status <= fqs_pkg::ST_ELEMENT;
                out_value  <= rd_val;
                out_pos    <= pos_trunc;
                out_last   <= scan_end;
                if (scan_end) begin
                  state <= S_IDLE;
                end
              end
            end
            fqs_pkg::ACT_SEARCH: begin
              if (adv) begin
                // Hold one match back so the final one can carry last
                if (match) begin
                  if (pend_valid) begin
                    out_valid  <= 1'b1;
                    out_status <= fqs_pkg::ST_FOUND;
                    out_value  <= pend_value;
                    out_pos    <= pend_pos;
                    out_last   <= 1'b0;
                  end
                  pend_valid <= 1'b1;
                  pend_value <= rd_val;
                  pend_pos   <= pos_trunc;
                end
                if (scan_end) begin
                  state <= S_FLUSH;
                end
              end
            end
            fqs_pkg::ACT_INSERT: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_FLUSH: begin
          if (out_free) begin
            out_valid <= 1'b1;
            out_last  <= 1'b1;
            if (pend_valid) begin
              out_status <= fqs_pkg::ST_FOUND;
              out_value  <= pend_value;
              out_pos    <= pend_pos;
            end else begin
              out_status <= fqs_pkg::ST_NOT_FOUND;
              out_value  <= '0;
              out_pos    <= '0;
            end
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign request.ready      = (state == S_IDLE);
  assign response.valid     = out_valid;
  assign response.status    = out_status;
  assign response.value_out = $signed(out_value);
  assign response.position  = out_pos;
  assign response.last      = out_last;

endmodule

### design/fqs_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// fqs_checker
// Port-level checks on the FIFO queue with search, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fqs_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_valid,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input fqs_pkg::status_t                   rsp_status,
  input logic signed [fqs_pkg::VALUE_W-1:0] rsp_value,
  input logic [fqs_pkg::POS_W-1:0]          rsp_position,
  input logic                               rsp_last
);

  // A pending response transaction stays offered until taken
  `ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response valid dropped while stalled")

  // One request at a time: ready falls right after an accepted transaction
  `ASSERT_NEXT(a_req_busy, req_valid && req_ready, !req_ready, "request ready after accept")

  // Only display and search spread over several results
  `ASSERT_SAME(a_multi, rsp_valid && !rsp_last, (rsp_status == fqs_pkg::ST_ELEMENT) || (rsp_status == fqs_pkg::ST_FOUND), "non-final result with single-result status")

  // Statuses without a payload carry zero value and position
  `ASSERT_SAME(a_zero, rsp_valid && ((rsp_status == fqs_pkg::ST_INSERTED) || (rsp_status == fqs_pkg::ST_NOT_FOUND) || (rsp_status == fqs_pkg::ST_EMPTY) || (rsp_status == fqs_pkg::ST_FULL)), (rsp_value == '0) && (rsp_position == '0), "nonzero payload on status without data")

endmodule

bind fifo_queue_with_search_unit fqs_checker u_fqs_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (request.valid),
  .req_ready    (request.ready),
  .rsp_valid    (response.valid),
  .rsp_ready    (response.ready),
  .rsp_status   (response.status),
  .rsp_value    (response.value_out),
  .rsp_position (response.position),
  .rsp_last     (response.last)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the FIFO queue with search. Requests come from a
// backlog with bursty gaps; responses see a rotating stall mask. Each accepted
// request updates a shadow ring and queues the replies it must produce, and
// every accepted response is compared field by field with the oldest one.
// ---------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH        = 16;
  localparam int RANDOM_ITEMS = 240;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PRINT_CAP    = 50;

  typedef struct {
    fqs_pkg::action_t   act;
    logic signed [31:0] arg;
    bit                 hold;   // wait for all replies before this one
  } queue_cmd_t;

  typedef struct {
    fqs_pkg::status_t          status;
    logic signed [31:0]        value;
    logic [fqs_pkg::POS_W-1:0] pos;
    logic                      last;
  } queue_reply_t;

  logic clk = 1'b0;
  logic rst;

  fqs_req_if req_if ();
  fqs_rsp_if rsp_if ();

  fifo_queue_with_search_unit #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (32)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .request  (req_if),
    .response (rsp_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  queue_cmd_t   cmd_backlog[$];
  queue_reply_t replies_due[$];

  // Shadow ring of the queue under test
  logic signed [31:0] ring_mem [DEPTH];
  int                 ring_head;
  int                 ring_fill;

  int  mismatch_count;
  int  cycle_count;
  bit  req_taken;

  // Stimulus planning state
  int                 plan_fill;
  logic signed [31:0] value_pool [4];

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  function automatic void post_reply(fqs_pkg::status_t s, logic signed [31:0] v, int p,
                                     bit l);
    queue_reply_t r;
    r.status = s;
    r.value  = v;
    r.pos    = fqs_pkg::POS_W'(p);
    r.last   = l;
    replies_due.push_back(r);
  endfunction

  // Update the shadow ring and queue the replies one request produces
  function automatic void apply_queue_action(fqs_pkg::action_t act, logic signed [31:0] arg);
    int hits;
    logic signed [31:0] v;
    hits = 0;
    if (act == fqs_pkg::ACT_INSERT) begin
      if (ring_fill >= DEPTH) begin
        post_reply(fqs_pkg::ST_FULL, '0, 0, 1'b1);
      end else begin
        ring_mem[(ring_head + ring_fill) % DEPTH] = arg;
        ring_fill++;
        post_reply(fqs_pkg::ST_INSERTED, '0, 0, 1'b1);
      end
    end else if (ring_fill == 0) begin
      post_reply(fqs_pkg::ST_EMPTY, '0, 0, 1'b1);
    end else if (act == fqs_pkg::ACT_DELETE) begin
      post_reply(fqs_pkg::ST_DELETED, ring_mem[ring_head], 0, 1'b1);
      ring_head = (ring_head + 1) % DEPTH;
      ring_fill--;
    end else if (act == fqs_pkg::ACT_DISPLAY) begin
      for (int k = 0; k < ring_fill; k++)
        post_reply(fqs_pkg::ST_ELEMENT, ring_mem[(ring_head + k) % DEPTH], k + 1,
                   k + 1 == ring_fill);
    end else begin
      for (int k = 0; k < ring_fill; k++) begin
        v = ring_mem[(ring_head + k) % DEPTH];
        if (v == arg) begin
          post_reply(fqs_pkg::ST_FOUND, v, k + 1, 1'b0);
          hits++;
        end
      end
      if (hits == 0)
        post_reply(fqs_pkg::ST_NOT_FOUND, '0, 0, 1'b1);
      else
        replies_due[replies_due.size() - 1].last = 1'b1;
    end
  endfunction

  // Append one request; track occupancy so phases can aim at full and empty
  task automatic queue_cmd(fqs_pkg::action_t act, logic signed [31:0] arg, bit hold = 1'b0);
    queue_cmd_t c;
    c.act  = act;
    c.arg  = arg;
    c.hold = hold;
    cmd_backlog.push_back(c);
    if (act == fqs_pkg::ACT_INSERT && plan_fill < DEPTH) plan_fill++;
    if (act == fqs_pkg::ACT_DELETE && plan_fill > 0) plan_fill--;
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 9) < 6) return value_pool[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  function automatic void refresh_pool();
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(0, 5))
        0:       value_pool[k] = 32'sh7FFF_FFFF;
        1:       value_pool[k] = 32'sh8000_0000;
        2:       value_pool[k] = 32'sh0000_0000;
        3:       value_pool[k] = -32'sd1;
        default: value_pool[k] = $urandom;
      endcase
    end
  endfunction

  // Request driver: bursts of random length separated by random gaps
  int         burst_left = 0;
  int         gap_left   = 0;
  queue_cmd_t cur_cmd;

  always @(negedge clk) begin
    if (rst) begin
      req_if.valid <= 1'b0;
    end else if (req_if.valid && !req_taken) begin
      // hold the transaction until it is accepted
    end else if (gap_left > 0 || cmd_backlog.size() == 0) begin
      if (gap_left > 0) gap_left--;
      req_if.valid <= 1'b0;
    end else if (cmd_backlog[0].hold && replies_due.size() != 0) begin
      req_if.valid <= 1'b0;
    end else begin
      cur_cmd = cmd_backlog.pop_front();
      req_if.valid   <= 1'b1;
      req_if.action  <= cur_cmd.act;
      req_if.operand <= cur_cmd.arg;
      if (burst_left == 0) begin
        if ($urandom_range(0, 3) == 0) begin
          burst_left = $urandom_range(20, 40);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 10);
          gap_left   = $urandom_range(1, 7);
        end
      end else begin
        burst_left--;
      end
    end
  end

  // Response ready: rotating 16-bit mask, bit 0 forced so stalls stay bounded
  int          mask_span  = 0;
  int          mask_phase = 0;
  logic [15:0] stall_mask = 16'hFFFF;

  always @(negedge clk) begin
    if (rst) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (mask_span == 0) begin
        mask_span  = $urandom_range(20, 80);
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
      end
      mask_span--;
      mask_phase = (mask_phase + 1) % 16;
      rsp_if.ready <= stall_mask[mask_phase];
    end
  end

  // Monitor: check replies, then predict from the accepted request
  queue_reply_t want;

  always @(posedge clk) begin
    if (rst) begin
      req_taken <= 1'b0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (replies_due.size() == 0) begin
          report_mismatch("unexpected response, status", 32'(rsp_if.status), '0);
        end else begin
          want = replies_due.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.value_out !== want.value)
            report_mismatch("value_out", rsp_if.value_out, want.value);
          if (rsp_if.position !== want.pos)
            report_mismatch("position", 32'(rsp_if.position), 32'(want.pos));
          if (rsp_if.last !== want.last)
            report_mismatch("last", 32'(rsp_if.last), 32'(want.last));
        end
      end
      if (req_if.valid && req_if.ready)
        apply_queue_action(req_if.action, req_if.operand);
      req_taken <= req_if.valid && req_if.ready;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int mode;
    int n;
    int pick;
    rst            = 1'b1;
    req_if.valid   = 1'b0;
    req_if.action  = fqs_pkg::ACT_INSERT;
    req_if.operand = '0;
    rsp_if.ready   = 1'b0;
    ring_head      = 0;
    ring_fill      = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    plan_fill      = 0;
    foreach (ring_mem[k]) ring_mem[k] = '0;

    // Directed: empty queue, field extremes, misses, multiple matches
    queue_cmd(fqs_pkg::ACT_DISPLAY, '0);
    queue_cmd(fqs_pkg::ACT_DELETE, 32'sh1234_5678);
    queue_cmd(fqs_pkg::ACT_SEARCH, '0);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'sh7FFF_FFFF);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'sh8000_0000);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'sh0000_0000);
    queue_cmd(fqs_pkg::ACT_INSERT, -32'sd1);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'sh5555_5555);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'shAAAA_AAAA);
    queue_cmd(fqs_pkg::ACT_SEARCH, -32'sd1);
    queue_cmd(fqs_pkg::ACT_SEARCH, 32'sd12345);
    queue_cmd(fqs_pkg::ACT_INSERT, -32'sd1);
    queue_cmd(fqs_pkg::ACT_SEARCH, -32'sd1, 1'b1);
    queue_cmd(fqs_pkg::ACT_DISPLAY, -32'sd1);
    queue_cmd(fqs_pkg::ACT_DELETE, '0);
    queue_cmd(fqs_pkg::ACT_SEARCH, 32'sh8000_0000);
    queue_cmd(fqs_pkg::ACT_SEARCH, 32'sh7FFF_FFFF);
    queue_cmd(fqs_pkg::ACT_DELETE, '0);
    queue_cmd(fqs_pkg::ACT_DELETE, '0);
    queue_cmd(fqs_pkg::ACT_DISPLAY, '0);
    queue_cmd(fqs_pkg::ACT_INSERT, 32'sd1);
    queue_cmd(fqs_pkg::ACT_SEARCH, 32'shAAAA_AAAA);

    // Random phases: fill to full, drain to empty, or mixed traffic
    n = 0;
    mode = 0;
    while (n < RANDOM_ITEMS) begin
      refresh_pool();
      if (n != 0) mode = $urandom_range(0, 3);
      pick = cmd_backlog.size();
      case (mode)
        0: begin
          queue_cmd(fqs_pkg::ACT_INSERT, pick_value(), n == 0 || $urandom_range(0, 2) == 0);
          while (plan_fill < DEPTH) queue_cmd(fqs_pkg::ACT_INSERT, pick_value());
          repeat ($urandom_range(1, 2)) queue_cmd(fqs_pkg::ACT_INSERT, pick_value());
          queue_cmd(fqs_pkg::ACT_DISPLAY, $urandom);
          queue_cmd(fqs_pkg::ACT_SEARCH, pick_value());
        end
        1: begin
          while (plan_fill > 0) queue_cmd(fqs_pkg::ACT_DELETE, $urandom);
          queue_cmd(fqs_pkg::ACT_DELETE, $urandom);
          queue_cmd(fqs_pkg::ACT_DISPLAY, $urandom);
          queue_cmd(fqs_pkg::ACT_SEARCH, pick_value());
        end
        default: begin
          repeat ($urandom_range(10, 20)) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3: queue_cmd(fqs_pkg::ACT_INSERT, pick_value());
              4, 5:       queue_cmd(fqs_pkg::ACT_DELETE, $urandom);
              6, 7, 8:    queue_cmd(fqs_pkg::ACT_SEARCH, pick_value());
              default:    queue_cmd(fqs_pkg::ACT_DISPLAY, $urandom);
            endcase
          end
        end
      endcase
      n += cmd_backlog.size() - pick;
    end

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    wait (cmd_backlog.size() == 0 && !req_if.valid);
    wait (replies_due.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && replies_due.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/fqs_pkg.sv
design/fqs_req_if.sv
design/fqs_rsp_if.sv
design/fqs_ram.sv
design/fifo_queue_with_search_unit.sv
design/fqs_checker.sv
tb/sv/tb_top.sv
